/* src/ptw_pkg.sv */
// shared types, constants and helpers for the four-level page table walker
package ptw_pkg;

  localparam int LEVELS_DEF = 4;
  localparam int VA_W       = 48;
  localparam int PA_W       = 52;
  localparam int ENTRY_W    = 64;
  localparam int IDX_W      = 9;
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_RESOLVE  = 2'd0,
    CMD_UNMAP    = 2'd1,
    CMD_REMAP    = 2'd2,
    CMD_RESPONSE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [PA_W-1:0]     mem_address;
    logic [ENTRY_W-1:0]  write_data;
    logic [PA_W-1:0]     result_addr;
    logic                not_mapped;
    logic                last;
  } result_t;

  // up to two results pushed into the result queue per cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } push_t;

  // 9-bit table index of a virtual address for a given level
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [2:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      3'd0, 3'd1: idx = va[20:12];
      3'd2:       idx = va[29:21];
      3'd3:       idx = va[38:30];
      3'd4:       idx = va[47:39];
      default:    idx = '0;
    endcase
    return idx;
  endfunction

endpackage

/* src/four_level_page_table_walker_core.sv */
// Page table walker: takes one request or memory read response per cycle unless in_stall
// is high. An accepted item is held in an input register and processed once the result
// queue has space; its results, up to two, then go into a four-entry result queue and
// leave through the out_ ports in order. Sustained rate is one item per cycle while the
// queue has space, set by the single step stage; items that produce a write and a flush
// are paced by the one-result-per-cycle output port, and the input stalls while an item
// waits in the input register and the queue holds more than two results.
// A walk issues at most one memory read request per level; read responses come back on
// the input channel with in_command set to response. The root table base register is
// written through the cfg_ port, which is always ready.
module four_level_page_table_walker_core #(
  parameter int LEVELS = ptw_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptw_pkg::PA_W-1:0]    cfg_root_table_base,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [ptw_pkg::VA_W-1:0]    in_virt_addr,
  input  logic [ptw_pkg::PA_W-1:0]    in_new_phys_addr,
  input  logic [ptw_pkg::ENTRY_W-1:0] in_read_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [ptw_pkg::PA_W-1:0]    out_mem_address,
  output logic [ptw_pkg::ENTRY_W-1:0] out_write_data,
  output logic [ptw_pkg::PA_W-1:0]    out_result_addr,
  output logic                        out_not_mapped,
  output logic                        out_last
);
  import ptw_pkg::*;

  logic [PA_W-1:0] root_r;
  logic            q_space;
  push_t           push;
  result_t         head;

  // root table base register, low 12 bits dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_r <= {cfg_root_table_base[PA_W-1:12], 12'h000};
    end
  end

  // walk step
  ptw_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_virt_addr     (in_virt_addr),
    .in_new_phys_addr (in_new_phys_addr),
    .in_read_data     (in_read_data),
    .root_base        (root_r),
    .q_space          (q_space),
    .push             (push)
  );

  // result queue
  ptw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind        = head.kind;
  assign out_mem_address = head.mem_address;
  assign out_write_data  = head.write_data;
  assign out_result_addr = head.result_addr;
  assign out_not_mapped  = head.not_mapped;
  assign out_last        = head.last;

endmodule

/* src/ptw_walk.sv */
// input register, walk state and combinational step logic
module ptw_walk #(
  parameter int LEVELS = ptw_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [ptw_pkg::VA_W-1:0]  in_virt_addr,
  input  logic [ptw_pkg::PA_W-1:0]  in_new_phys_addr,
  input  logic [ptw_pkg::ENTRY_W-1:0] in_read_data,
  input  logic [ptw_pkg::PA_W-1:0]  root_base,
  input  logic                      q_space,
  output ptw_pkg::push_t            push
);
  import ptw_pkg::*;

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  cmd_t               s1_cmd_r;
  logic [VA_W-1:0]    s1_virt_r;
  logic [PA_W-1:0]    s1_new_r;
  logic [ENTRY_W-1:0] s1_data_r;

  // walk state
  logic            busy_r, busy_nxt;
  cmd_t            op_r, op_nxt;
  logic [2:0]      level_r, level_nxt;
  logic [VA_W-1:0] virt_r, virt_nxt;
  logic [PA_W-1:0] frame_r, frame_nxt;
  logic [PA_W-1:0] leaf_r, leaf_nxt;

  logic            go;
  logic            in_acc;
  logic [2:0]      level_dn;
  logic [PA_W-1:0] next_addr;
  logic [PA_W-1:0] virt_ext;
  logic [ENTRY_W-1:0] remap_val;

  assign go       = s1_valid_r && q_space;
  assign in_stall = s1_valid_r && !q_space;
  assign in_acc   = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc ? 1'b1 : (go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_virt_r <= in_virt_addr;
      s1_new_r  <= in_new_phys_addr;
      s1_data_r <= in_read_data;
    end
  end

  // shared address pieces
  assign level_dn  = level_r - 3'd1;
  assign next_addr = {s1_data_r[PA_W-1:12], level_index(virt_r, level_dn), 3'b000};
  assign virt_ext  = {{(PA_W-VA_W){1'b0}}, virt_r};
  assign remap_val = {s1_data_r[ENTRY_W-1:PA_W], frame_r[PA_W-1:12],
                      s1_data_r[11:1], 1'b1};

  // step logic: next state and results
  always_comb begin
    busy_nxt  = busy_r;
    op_nxt    = op_r;
    level_nxt = level_r;
    virt_nxt  = virt_r;
    frame_nxt = frame_r;
    leaf_nxt  = leaf_r;
    push      = '0;
    if (go) begin
      if (s1_cmd_r != CMD_RESPONSE) begin
        // new request starts a walk at the top table if no walk is busy; otherwise it is dropped
        if (!busy_r) begin
          busy_nxt  = 1'b1;
          op_nxt    = s1_cmd_r;
          level_nxt = 3'(LEVELS);
          virt_nxt  = s1_virt_r;
          frame_nxt = s1_new_r;
          push.cnt  = 2'd1;
          push.res0.kind = KIND_READ;
          push.res0.mem_address = {root_base[PA_W-1:12],
                                   level_index(s1_virt_r, 3'(LEVELS)), 3'b000};
        end
      end else if (busy_r) begin
        if (level_r > 3'd1) begin
          // intermediate entry
          if (!s1_data_r[0]) begin
            busy_nxt = 1'b0;
            push.cnt = 2'd1;
            push.res0.kind       = KIND_DONE;
            push.res0.not_mapped = 1'b1;
            push.res0.last       = 1'b1;
          end else begin
            level_nxt = level_dn;
            push.cnt  = 2'd1;
            push.res0.kind        = KIND_READ;
            push.res0.mem_address = next_addr;
            if (level_dn == 3'd1) begin
              leaf_nxt = next_addr;
              if (op_r == CMD_UNMAP) begin
                busy_nxt = 1'b0;
                push.cnt = 2'd2;
                push.res0.kind        = KIND_WRITE;
                push.res1.kind        = KIND_FLUSH;
                push.res1.result_addr = virt_ext;
                push.res1.last        = 1'b1;
              end
            end
          end
        end else begin
          // leaf entry
          busy_nxt = 1'b0;
          case (op_r)
            CMD_REMAP, CMD_UNMAP: begin
              push.cnt = 2'd2;
              push.res0.kind        = KIND_WRITE;
              push.res0.mem_address = leaf_r;
              push.res0.write_data  = (op_r == CMD_REMAP) ? remap_val : '0;
              push.res1.kind        = KIND_FLUSH;
              push.res1.result_addr = virt_ext;
              push.res1.last        = 1'b1;
            end
            default: begin
              push.cnt = 2'd1;
              push.res0.kind = KIND_DONE;
              push.res0.last = 1'b1;
              if (!s1_data_r[0]) begin
                push.res0.not_mapped = 1'b1;
              end else begin
                push.res0.result_addr = {s1_data_r[PA_W-1:12], 12'h000};
              end
            end
          endcase
        end
      end
    end
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      op_r    <= CMD_RESOLVE;
      level_r <= '0;
      virt_r  <= '0;
      frame_r <= '0;
      leaf_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      op_r    <= op_nxt;
      level_r <= level_nxt;
      virt_r  <= virt_nxt;
      frame_r <= frame_nxt;
      leaf_r  <= leaf_nxt;
    end
  end

  // checks
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (level_r >= 3'd1 && level_r <= 3'(LEVELS)))
    else $error("walk level out of range while busy");

  a_idle_response: assert property (@(posedge clk) disable iff (!rst_n)
    (go && s1_cmd_r == CMD_RESPONSE && !busy_r) |-> push.cnt == 2'd0)
    else $error("response while idle produced a result");

endmodule

/* src/ptw_outq.sv */
// result queue taking up to two results per cycle and giving one
module ptw_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  ptw_pkg::push_t   push,
  output logic             q_space,
  output logic             out_valid,
  input  logic             out_stall,
  output ptw_pkg::result_t head
);
  import ptw_pkg::*;

  result_t               mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_PTR_W:0]     count_r, count_nxt;
  logic                  pop;
  logic [OQ_PTR_W-1:0]   wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign q_space   = (count_r <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + OQ_PTR_W'(1);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + OQ_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (OQ_PTR_W+1)'(push.cnt) - (OQ_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (count_r + (OQ_PTR_W+1)'(push.cnt) <= (OQ_PTR_W+1)'(OQ_DEPTH)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OQ_PTR_W+1)'(OQ_DEPTH))
    else $error("result queue count out of range");

endmodule
